[hw/rtl/jsu_pkg.sv]
// Shared types and codes for the JSON string unescape block.
// No dependencies; imported by jsu_decode, json_string_unescape and jsu_checker.
`timescale 1ns / 1ps

package jsu_pkg;

  // Decoder phases
  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_BODY = 2'd1;
  localparam logic [1:0] PH_ESC  = 2'd2;
  localparam logic [1:0] PH_HEX  = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_EXPECTED_QUOTE = 2'd0;
  localparam logic [1:0] ERR_INVALID_CHAR   = 2'd1;
  localparam logic [1:0] ERR_INVALID_ESCAPE = 2'd2;
  localparam logic [1:0] ERR_BAD_HEX        = 2'd3;

  // Most results one input byte can cause
  localparam int unsigned MAX_RESULTS = 3;

  localparam logic [15:0] LIMIT_RESET = 16'h7FFF;

  // Decoder state carried between items
  typedef struct packed {
    logic [1:0]  phase;
    logic [1:0]  hex_seen;
    logic [15:0] hex_acc;
    logic [15:0] count;
    logic        dropped;
  } jsu_state_t;

  // One result item
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [1:0] error_code;
    logic       truncated;
    logic       last;
  } result_t;

endpackage

[hw/rtl/json_string_unescape.sv]
// Top level of the JSON string unescape block: state, limit register, result holding.
// Depends on jsu_pkg and jsu_decode.
`timescale 1ns / 1ps

// Decodes a JSON string literal fed one raw byte per item, starting at its opening
// quote, and returns decoded bytes, an end result (with a truncation flag) or an
// error. An item is decoded in the cycle it is accepted and its results appear
// registered the next cycle. A byte is taken every cycle as long as results are
// drained; a byte that causes several results (up to three, only the last \u
// digit causes more) holds the byte port until all but its last are taken, as the
// three-entry result holding register hands out one result per cycle unless
// stalled. The limit register is always ready and takes effect on the next byte.
module json_string_unescape (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  in_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  kind,
  output logic [7:0]  value,
  output logic [1:0]  error_code,
  output logic        truncated,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import jsu_pkg::*;

  jsu_state_t        state;
  jsu_state_t        state_next;
  logic [15:0]       length_limit;
  logic [1:0]        result_count;
  result_t [2:0]     results;
  result_t [2:0]     hold;
  logic [1:0]        hold_count;
  logic [1:0]        hold_ptr;
  logic              take_out;
  logic              accept;
  result_t           cur;

  jsu_decode u_decode (
    .state        (state),
    .length_limit (length_limit),
    .in_byte      (in_byte),
    .state_next   (state_next),
    .result_count (result_count),
    .results      (results)
  );

  // Handshakes
  assign cfg_ready = 1'b1;
  assign result_valid = (hold_count != 2'd0);
  assign take_out = result_valid && !result_stall;
  assign byte_stall = !((hold_count == 2'd0) || (hold_count == 2'd1 && take_out));
  assign accept = byte_valid && !byte_stall;

  // Present the current held result
  assign cur = hold[hold_ptr];
  assign kind = cur.kind;
  assign value = cur.value;
  assign error_code = cur.error_code;
  assign truncated = cur.truncated;
  assign last = cur.last;

  // Decoder state and limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
      length_limit <= LIMIT_RESET;
    end else begin
      if (accept) state <= state_next;
      if (cfg_valid && cfg_ready) length_limit <= cfg_data;
    end
  end

  // Load results of an accepted item, or advance through held ones
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_count <= 2'd0;
      hold_ptr <= 2'd0;
    end else if (accept) begin
      hold_count <= result_count;
      hold_ptr <= 2'd0;
    end else if (take_out) begin
      hold_count <= hold_count - 2'd1;
      hold_ptr <= hold_ptr + 2'd1;
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) hold <= results;
  end

endmodule

[hw/rtl/jsu_decode.sv]
// Combinational decode of one input byte against the current decoder state.
// Depends on jsu_pkg for state, result types and codes.
`timescale 1ns / 1ps

module jsu_decode (
  input  jsu_pkg::jsu_state_t            state,
  input  logic [15:0]                    length_limit,
  input  logic [7:0]                     in_byte,
  output jsu_pkg::jsu_state_t            state_next,
  output logic [1:0]                     result_count,
  output jsu_pkg::result_t [2:0]         results
);
  import jsu_pkg::*;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_CTRL_MAX = 8'h1F;

  // Hex digit value, bit 4 marks a valid digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= "0" && c <= "9") r = {1'b1, 4'(c - "0")};
    else if (c >= "A" && c <= "F") r = {1'b1, 4'(c - "A" + 8'd10)};
    else if (c >= "a" && c <= "f") r = {1'b1, 4'(c - "a" + 8'd10)};
    return r;
  endfunction

  logic [4:0]  hv;
  logic [15:0] acc_shift;
  logic [7:0]  cand [3];
  logic [1:0]  cand_n;
  logic        special;
  result_t     spec_res;
  logic        room_ok;
  logic [15:0] room;
  logic [1:0]  take;

  always_comb begin
    hv = hex_value(in_byte);
    acc_shift = {state.hex_acc[11:0], hv[3:0]};
    state_next = state;
    special = 1'b0;
    spec_res = '0;
    cand[0] = 8'd0;
    cand[1] = 8'd0;
    cand[2] = 8'd0;
    cand_n = 2'd0;

    // Phase dispatch: produce candidate bytes or one special result
    case (state.phase)
      PH_WAIT: begin
        if (in_byte == CH_QUOTE) begin
          state_next.phase = PH_BODY;
          state_next.count = 16'd0;
          state_next.dropped = 1'b0;
        end else begin
          special = 1'b1;
          spec_res.kind = KIND_ERROR;
          spec_res.error_code = ERR_EXPECTED_QUOTE;
        end
      end
      PH_BODY: begin
        if (in_byte == CH_QUOTE) begin
          special = 1'b1;
          spec_res.kind = KIND_END;
          spec_res.truncated = state.dropped;
          state_next.phase = PH_WAIT;
        end else if (in_byte == CH_BSLASH) begin
          state_next.phase = PH_ESC;
        end else if (in_byte <= CH_CTRL_MAX || in_byte == CH_DEL) begin
          special = 1'b1;
          spec_res.kind = KIND_ERROR;
          spec_res.error_code = ERR_INVALID_CHAR;
          state_next.phase = PH_WAIT;
        end else begin
          cand[0] = in_byte;
          cand_n = 2'd1;
        end
      end
      PH_ESC: begin
        state_next.phase = PH_BODY;
        cand_n = 2'd1;
        case (in_byte)
          CH_QUOTE:  cand[0] = CH_QUOTE;
          CH_BSLASH: cand[0] = CH_BSLASH;
          CH_SLASH:  cand[0] = CH_SLASH;
          "b":       cand[0] = 8'h08;
          "f":       cand[0] = 8'h0C;
          "n":       cand[0] = 8'h0A;
          "r":       cand[0] = 8'h0D;
          "t":       cand[0] = 8'h09;
          "u": begin
            cand_n = 2'd0;
            state_next.phase = PH_HEX;
            state_next.hex_seen = 2'd0;
            state_next.hex_acc = 16'd0;
          end
          default: begin
            cand_n = 2'd0;
            special = 1'b1;
            spec_res.kind = KIND_ERROR;
            spec_res.error_code = ERR_INVALID_ESCAPE;
            state_next.phase = PH_WAIT;
          end
        endcase
      end
      default: begin
        if (!hv[4]) begin
          special = 1'b1;
          spec_res.kind = KIND_ERROR;
          spec_res.error_code = ERR_BAD_HEX;
          state_next.phase = PH_WAIT;
        end else begin
          state_next.hex_acc = acc_shift;
          if (state.hex_seen != 2'd3) begin
            state_next.hex_seen = state.hex_seen + 2'd1;
          end else begin
            // Fourth digit: encode the code unit as UTF-8
            state_next.hex_seen = 2'd0;
            state_next.phase = PH_BODY;
            if (acc_shift <= 16'h007F) begin
              cand[0] = acc_shift[7:0];
              cand_n = 2'd1;
            end else if (acc_shift <= 16'h07FF) begin
              cand[0] = 8'hC0 | {3'd0, acc_shift[10:6]};
              cand[1] = 8'h80 | {2'd0, acc_shift[5:0]};
              cand_n = 2'd2;
            end else begin
              cand[0] = 8'hE0 | {4'd0, acc_shift[15:12]};
              cand[1] = 8'h80 | {2'd0, acc_shift[11:6]};
              cand[2] = 8'h80 | {2'd0, acc_shift[5:0]};
              cand_n = 2'd3;
            end
          end
        end
      end
    endcase

    // Apply the length limit: keep only as many bytes as room allows
    room_ok = state_next.count < length_limit;
    room = length_limit - state_next.count;
    if (!room_ok) take = 2'd0;
    else if (room >= {14'd0, cand_n}) take = cand_n;
    else take = room[1:0];
    state_next.count = state_next.count + {14'd0, take};
    if (take != cand_n) state_next.dropped = 1'b1;

    // Pack results, flag the last one
    for (int i = 0; i < MAX_RESULTS; i++) begin
      results[i] = '0;
      results[i].kind = KIND_DATA;
      results[i].value = cand[i];
      results[i].last = (take == 2'(i + 1));
    end
    result_count = take;
    if (special) begin
      results[0] = spec_res;
      results[0].last = 1'b1;
      result_count = 2'd1;
    end
  end

endmodule

[hw/rtl/jsu_checker.sv]
// Port-level checks on the JSON string unescape block, bound to the top level.
// Depends on jsu_pkg for result kind codes.
`timescale 1ns / 1ps

module jsu_checker (
  input logic       clk,
  input logic       rst,
  input logic       result_valid,
  input logic       result_stall,
  input logic [1:0] kind,
  input logic [7:0] value,
  input logic [1:0] error_code,
  input logic       truncated,
  input logic       last
);
  import jsu_pkg::*;

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result pending after reset");

  // Hold a stalled result
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(kind) && $stable(value)
      && $stable(error_code) && $stable(truncated) && $stable(last))
    else $error("stalled result changed");

  // End and error results carry no byte and close their item
  a_special_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind != KIND_DATA |-> value == 8'd0 && last)
    else $error("end or error result malformed");

  // Data results carry no error code and no truncation flag
  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == KIND_DATA |-> error_code == 2'd0 && !truncated)
    else $error("data result carries status bits");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .kind         (kind),
  .value        (value),
  .error_code   (error_code),
  .truncated    (truncated),
  .last         (last)
);
